// ===== sv/prewitt_edge_magnitude_unit_defines.svh =====
// Assertion shorthands used by the checker file.
`ifndef PREWITT_EDGE_MAGNITUDE_UNIT_DEFINES_SVH
`define PREWITT_EDGE_MAGNITUDE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define PEM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pem check failed");

// Next-cycle implication, clocked on clk, off while rst is high.
`define PEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pem check failed");

`endif

// ===== sv/pem_pkg.sv =====
package pem_pkg;

  // Q0.16 luma weights, they sum to 65536
  localparam logic [15:0] GRAY_WR = 16'd19595;
  localparam logic [15:0] GRAY_WG = 16'd38470;
  localparam logic [15:0] GRAY_WB = 16'd7471;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // |gx|, |gy| <= 765
  localparam int unsigned GRAD_W = 10;
  localparam int unsigned SQ_W = 2 * GRAD_W;
  localparam int unsigned SUMSQ_W = SQ_W + 1;
  // sqrt runs on 16 bits only; anything at or above 2^16 saturates
  localparam int unsigned ROOT_IN_W = 16;
  localparam int unsigned ROOT_W = ROOT_IN_W + 1;
  localparam int unsigned ROOT_STEPS = ROOT_IN_W / 2;
  localparam int unsigned STEP_W = $clog2(ROOT_STEPS);
  localparam logic [7:0] EDGE_MAX = 8'd255;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [GRAD_W-1:0] abs_gx;
    logic [GRAD_W-1:0] abs_gy;
    logic              row_end;
    logic              frame_end;
  } grad_t;

  typedef struct packed {
    logic  valid;
    grad_t data;
  } grad_xfer_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_GRAY,
    F_SUM
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQUARE,
    B_SUM,
    B_ROOT,
    B_OUT
  } back_state_t;

endpackage

// ===== sv/prewitt_edge_magnitude_unit.sv =====
// Prewitt edge magnitude over a raster RGB stream. One pixel per input
// transfer, row by row; each pixel is reduced to 8-bit luma with Q0.16 weights
// 19595/38470/7471, pushed through two line stores (MAX_WIDTH x 8 each) and a
// 3x3 window, and the horizontal and vertical Prewitt sums are combined as
// floor(sqrt(gx^2 + gy^2)), saturated to 255. Only interior pixels give a
// result, so a W x H frame yields (W-2) x (H-2) output transfers; row_end
// flags the last result of each output row and frame_end the last of the
// frame. image_width (index 0, clamped to 3..MAX_WIDTH) and image_height
// (index 1, at least 3) are written on the cfg port, which never stalls, and
// take effect at the next pixel, in the middle of a frame too. The pixel
// front end steps through accept, luma multiply, then window update and line
// store write-back, where it stalls if it has a result and the queue is full,
// and feeds a two-entry queue. The magnitude back end steps through dequeue,
// square, add, bit-serial square root and an output state held until the
// result is taken; it takes no new entry before then. Inside a frame the square
// root sets the pace; on border pixels, which give no result, the front end runs ahead.
// Line stores need no initialization after reset.
module prewitt_edge_magnitude_unit import pem_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            edge_level,
  output logic                  row_end,
  output logic                  frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [11:0] image_width;
  logic [15:0] image_height;

  grad_xfer_t q_push, q_head;
  logic       q_full, q_pop;

  // config writes are always accepted; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // front end: luma, line stores, window, raster counters, gradient sums
  pem_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .image_width  (image_width),
    .image_height (image_height),
    .push         (q_push),
    .full         (q_full)
  );

  // two-entry queue of |gx|, |gy| and end flags; front stalls only when full
  pem_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .full (q_full),
    .head (q_head),
    .pop  (q_pop)
  );

  // back end: squares, bit-serial root, saturation, output register
  pem_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .edge_level (edge_level),
    .row_end    (row_end),
    .frame_end  (frame_end)
  );

endmodule

// ===== sv/pem_front.sv =====
module pem_front import pem_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [11:0] image_width,
  input  logic [15:0] image_height,
  output grad_xfer_t  push,
  input  logic        full
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (CW + 1 > 12) ? CW + 1 : 12;
  localparam logic [WW-1:0] WMAX = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] WMIN = WW'(3);

  front_state_t state, state_next;

  logic [CW-1:0] column_count;
  logic [15:0]   row_count;

  logic [7:0]    red_q, green_q, blue_q;
  logic [CW-1:0] col_q;
  logic          produce_q, row_end_q, frame_end_q;
  logic [7:0]    gray, older_q, newer_q;
  logic [7:0]    window [6];

  logic [7:0] older_mem [MAX_WIDTH];
  logic [7:0] newer_mem [MAX_WIDTH];

  logic [WW-1:0] width_ext, width_eff;
  logic [15:0]   height_eff;
  logic          last_col, last_row, accept, fire;
  logic [23:0]   gray_sum;
  logic [10:0]   gx, gy;
  logic [10:0]   ax, ay;

  always_comb begin
    width_ext = WW'(image_width);
    priority if (width_ext < WMIN) begin
      width_eff = WMIN;
    end else if (width_ext > WMAX) begin
      width_eff = WMAX;
    end else begin
      width_eff = width_ext;
    end
    height_eff = (image_height < 16'd3) ? 16'd3 : image_height;
  end

  assign last_col = (WW'(column_count) >= width_eff - WW'(1));
  assign last_row = (row_count >= height_eff - 16'd1);
  assign accept   = in_valid & in_ready;

  assign gray_sum = 24'(GRAY_WR) * 24'(red_q) + 24'(GRAY_WG) * 24'(green_q)
                  + 24'(GRAY_WB) * 24'(blue_q);

  // top = older_q, mid = newer_q, bot = gray; 11-bit wrap gives two's complement
  assign gx = 11'(older_q) + 11'(newer_q) + 11'(gray)
            - 11'(window[0]) - 11'(window[1]) - 11'(window[2]);
  assign gy = 11'(window[2]) + 11'(window[5]) + 11'(gray)
            - 11'(window[0]) - 11'(window[3]) - 11'(older_q);
  assign ax = gx[10] ? (11'd0 - gx) : gx;
  assign ay = gy[10] ? (11'd0 - gy) : gy;

  assign fire = (state == F_SUM) && (!produce_q || !full);

  always_comb begin
    push.valid          = (state == F_SUM) && produce_q && !full;
    push.data.abs_gx    = ax[GRAD_W-1:0];
    push.data.abs_gy    = ay[GRAD_W-1:0];
    push.data.row_end   = row_end_q;
    push.data.frame_end = frame_end_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          state_next = F_GRAY;
        end
      end
      F_GRAY: begin
        state_next = F_SUM;
      end
      F_SUM: begin
        if (fire) begin
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? 16'd0 : row_count + 16'd1;
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_q       <= red;
      green_q     <= green;
      blue_q      <= blue;
      col_q       <= column_count;
      produce_q   <= (column_count >= CW'(2)) && (row_count >= 16'd2);
      row_end_q   <= last_col;
      frame_end_q <= last_col & last_row;
    end
    if (state == F_GRAY) begin
      gray <= gray_sum[23:16];
    end
  end

  // line stores: read on accept, written back once the gray value is known
  always_ff @(posedge clk) begin
    if (accept) begin
      older_q <= older_mem[column_count];
      newer_q <= newer_mem[column_count];
    end
    if (fire) begin
      older_mem[col_q] <= newer_q;
      newer_mem[col_q] <= gray;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        window[i] <= '0;
      end
    end else if (fire) begin
      window[0] <= window[3];
      window[1] <= window[4];
      window[2] <= window[5];
      window[3] <= older_q;
      window[4] <= newer_q;
      window[5] <= gray;
    end
  end

endmodule

// ===== sv/pem_queue.sv =====
module pem_queue import pem_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  grad_xfer_t push,
  output logic       full,
  output grad_xfer_t head,
  input  logic       pop
);

  grad_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      priority if (push.valid && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push.valid) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.data;
    end
  end

endmodule

// ===== sv/pem_back.sv =====
module pem_back import pem_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  grad_xfer_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] edge_level,
  output logic       row_end,
  output logic       frame_end
);

  back_state_t state, state_next;

  logic [GRAD_W-1:0]  ax, ay;
  logic [SQ_W-1:0]    sq_x, sq_y;
  logic [SUMSQ_W-1:0] sum_sq;
  logic               sat;
  logic [ROOT_W-1:0]  rem, root, bitv;
  logic [ROOT_W-1:0]  trial, root_next;
  logic               take;
  logic [STEP_W-1:0]  step;
  logic               last_step;

  assign sum_sq    = SUMSQ_W'(sq_x) + SUMSQ_W'(sq_y);
  assign trial     = root + bitv;
  assign take      = (rem >= trial);
  assign root_next = take ? ((root >> 1) + bitv) : (root >> 1);
  assign last_step = (step == STEP_W'(ROOT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = B_SQUARE;
        end
      end
      B_SQUARE: begin
        state_next = B_SUM;
      end
      B_SUM: begin
        state_next = B_ROOT;
      end
      B_ROOT: begin
        if (last_step) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        ax        <= head.data.abs_gx;
        ay        <= head.data.abs_gy;
        row_end   <= head.data.row_end;
        frame_end <= head.data.frame_end;
      end
      B_SQUARE: begin
        sq_x <= ax * ax;
        sq_y <= ay * ay;
      end
      B_SUM: begin
        sat  <= |sum_sq[SUMSQ_W-1:ROOT_IN_W];
        rem  <= ROOT_W'(sum_sq[ROOT_IN_W-1:0]);
        root <= '0;
        bitv <= ROOT_W'(1) << (ROOT_IN_W - 2);
        step <= '0;
      end
      B_ROOT: begin
        // one result bit per cycle, restoring digit-by-digit root
        if (take) begin
          rem <= rem - trial;
        end
        root <= root_next;
        bitv <= bitv >> 2;
        step <= step + STEP_W'(1);
        if (last_step) begin
          edge_level <= sat ? EDGE_MAX : root_next[7:0];
        end
      end
      B_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/pem_checker.sv =====
`include "prewitt_edge_magnitude_unit_defines.svh"

module pem_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] edge_level,
  input logic       row_end,
  input logic       frame_end
);

  logic [9:0] out_payload;

  assign out_payload = {edge_level, row_end, frame_end};

  // a stalled result holds its payload
  `PEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // the frame's last result is also its row's last
  `PEM_ASSERT_SAME(a_frame_ends_row, out_valid && frame_end, row_end)

  // reset leaves the block empty and ready for a pixel
  `PEM_ASSERT_SAME(a_reset_empty, $past(rst), !out_valid && in_ready)

  // a pixel keeps the front end busy for the cycle after its transfer
  `PEM_ASSERT_NEXT(a_front_busy, in_valid && in_ready, !in_ready)

endmodule

bind prewitt_edge_magnitude_unit pem_checker u_pem_checker (.*);
